// ----- sv/mpc_pkg.sv -----
package mpc_pkg;

    // default tally width
    localparam int COUNT_WIDTH_DEF = 12;

    // reported count widths and limits
    localparam int OUT_COUNT_W = 12;
    localparam int OUT_TOTAL_W = 13;
    localparam int OUT_COUNT_MAX = 4095;
    localparam int OUT_TOTAL_MAX = 8190;

    localparam int NUM_BASES = 5;

    // level in hundredths, one quotient bit per step
    localparam int LEVEL_W = 7;
    localparam int STEP_W = 3;
    localparam int LEVEL_SCALE = 200;

    // column snapshot layout, counts follow the header part
    localparam int SNAP_POS_LSB = 0;
    localparam int SNAP_WIN_LSB = 32;
    localparam int SNAP_FLAG_BIT = 47;
    localparam int SNAP_CNT_LSB = 48;

    localparam int QUEUE_DEPTH_DEF = 2;

    // reference base codes
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_T = 3'd1;
    localparam logic [2:0] BASE_C = 3'd2;
    localparam logic [2:0] BASE_G = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;
    localparam logic [2:0] SUB_ABSENT = 3'd5;

    // item kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // context classes
    localparam logic [1:0] CTX_NONE = 2'd0;
    localparam logic [1:0] CTX_CG = 2'd1;
    localparam logic [1:0] CTX_CHG = 2'd2;
    localparam logic [1:0] CTX_CHH = 2'd3;

    // read base codes (one-hot nucleotide)
    localparam logic [3:0] READ_A = 4'd1;
    localparam logic [3:0] READ_C = 4'd2;
    localparam logic [3:0] READ_G = 4'd4;
    localparam logic [3:0] READ_T = 4'd8;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ref_minus2;
        logic [2:0]  ref_minus1;
        logic [2:0]  ref_center;
        logic [2:0]  ref_plus1;
        logic [2:0]  ref_plus2;
        logic        window_in_bounds;
        logic [31:0] column_position;
        logic [3:0]  read_base;
        logic        reverse_strand;
        logic        is_indel;
        logic        last_in_column;
    } mpc_in_t;

    typedef struct packed {
        logic [32:0] position_one_based;
        logic [2:0]  ref_base;
        logic [1:0]  context_class;
        logic [2:0]  sub_second;
        logic [59:0] forward_counts;
        logic [59:0] reverse_counts;
        logic [11:0] meth_count;
        logic [12:0] total_count;
        logic [6:0]  level_hundredths;
        logic        level_valid;
    } mpc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } mpc_state_t;

    function automatic logic [2:0] norm_base(input logic [2:0] code);
        norm_base = (code > BASE_N) ? BASE_N : code;
    endfunction

    function automatic logic [2:0] complement_base(input logic [2:0] code);
        case (code)
            BASE_A:  complement_base = BASE_T;
            BASE_T:  complement_base = BASE_A;
            BASE_C:  complement_base = BASE_G;
            BASE_G:  complement_base = BASE_C;
            default: complement_base = BASE_N;
        endcase
    endfunction

    function automatic logic [2:0] read_to_base(input logic [3:0] code);
        case (code)
            READ_A:  read_to_base = BASE_A;
            READ_C:  read_to_base = BASE_C;
            READ_G:  read_to_base = BASE_G;
            READ_T:  read_to_base = BASE_T;
            default: read_to_base = BASE_N;
        endcase
    endfunction

endpackage

// ----- sv/mpc_front.sv -----
module mpc_front #(
    parameter int COUNT_WIDTH = mpc_pkg::COUNT_WIDTH_DEF,
    parameter int SNAP_W = mpc_pkg::SNAP_CNT_LSB + 10 * COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  mpc_pkg::mpc_in_t  item,
    output logic              snap_push,
    output logic [SNAP_W-1:0] snap
);
    import mpc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]             win_reg [NUM_BASES];
    logic [2:0]             win_next [NUM_BASES];
    logic                   flag_reg, flag_next;
    logic [31:0]            pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] fwd_reg [NUM_BASES];
    logic [COUNT_WIDTH-1:0] fwd_next [NUM_BASES];
    logic [COUNT_WIDTH-1:0] rev_reg [NUM_BASES];
    logic [COUNT_WIDTH-1:0] rev_next [NUM_BASES];
    logic [2:0]             hdr_win [NUM_BASES];
    logic [2:0]             read_idx;
    logic                   is_header, is_count;

    assign hdr_win[0] = norm_base(item.ref_minus2);
    assign hdr_win[1] = norm_base(item.ref_minus1);
    assign hdr_win[2] = norm_base(item.ref_center);
    assign hdr_win[3] = norm_base(item.ref_plus1);
    assign hdr_win[4] = norm_base(item.ref_plus2);

    assign read_idx  = read_to_base(item.read_base);
    assign is_header = take && (item.kind == KIND_HEADER);
    assign is_count  = take && (item.kind == KIND_READ) && !item.is_indel;

    // one lane per base and strand, saturating
    always_comb
    begin
        flag_next = is_header ? item.window_in_bounds : flag_reg;
        pos_next  = is_header ? item.column_position : pos_reg;
        for (int i = 0; i < NUM_BASES; i++)
        begin
            win_next[i] = is_header ? hdr_win[i] : win_reg[i];
            fwd_next[i] = fwd_reg[i];
            rev_next[i] = rev_reg[i];
            if (is_header)
            begin
                fwd_next[i] = '0;
                rev_next[i] = '0;
            end
            else if (is_count && (read_idx == 3'(i)))
            begin
                if (!item.reverse_strand && (fwd_reg[i] != CNT_MAX))
                    fwd_next[i] = fwd_reg[i] + 1'b1;
                if (item.reverse_strand && (rev_reg[i] != CNT_MAX))
                    rev_next[i] = rev_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            pos_reg  <= '0;
            for (int i = 0; i < NUM_BASES; i++)
            begin
                win_reg[i] <= BASE_N;
                fwd_reg[i] <= '0;
                rev_reg[i] <= '0;
            end
        end
        else
        begin
            flag_reg <= flag_next;
            pos_reg  <= pos_next;
            for (int i = 0; i < NUM_BASES; i++)
            begin
                win_reg[i] <= win_next[i];
                fwd_reg[i] <= fwd_next[i];
                rev_reg[i] <= rev_next[i];
            end
        end
    end

    // column snapshot includes this item's own update
    always_comb
    begin
        snap = '0;
        snap[SNAP_POS_LSB +: 32] = pos_next;
        snap[SNAP_FLAG_BIT] = flag_next;
        for (int i = 0; i < NUM_BASES; i++)
        begin
            snap[SNAP_WIN_LSB + 3 * i +: 3] = win_next[i];
            snap[SNAP_CNT_LSB + COUNT_WIDTH * i +: COUNT_WIDTH] = fwd_next[i];
            snap[SNAP_CNT_LSB + COUNT_WIDTH * (NUM_BASES + i) +: COUNT_WIDTH] = rev_next[i];
        end
    end

    assign snap_push = take && item.last_in_column;

endmodule

// ----- sv/mpc_fifo.sv -----
module mpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- sv/mpc_back.sv -----
module mpc_back #(
    parameter int COUNT_WIDTH = mpc_pkg::COUNT_WIDTH_DEF,
    parameter int SNAP_W = mpc_pkg::SNAP_CNT_LSB + 10 * COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SNAP_W-1:0] snap,
    input  logic              snap_empty,
    output logic              snap_pop,
    output mpc_pkg::mpc_out_t result,
    output logic              empty,
    input  logic              pop
);
    import mpc_pkg::*;

    localparam int TOT_W = COUNT_WIDTH + 1;
    localparam int NUM_W = COUNT_WIDTH + 9;
    localparam int SAT_W = (TOT_W > OUT_TOTAL_W) ? TOT_W : OUT_TOTAL_W;

    mpc_state_t state_reg, state_next;

    logic [SNAP_W-1:0]      snap_reg;
    logic [1:0]             ctx_reg, ctx_next;
    logic [2:0]             sub_reg, sub_next;
    logic [COUNT_WIDTH-1:0] meth_reg, meth_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [NUM_W-1:0]       rem_reg, dsh_reg;
    logic [LEVEL_W-1:0]     quo_reg;
    logic [STEP_W-1:0]      step_reg;
    mpc_out_t               result_reg, result_next;
    logic                   valid_reg;

    logic [2:0]             win [NUM_BASES];
    logic [COUNT_WIDTH-1:0] fwd [NUM_BASES];
    logic [COUNT_WIDTH-1:0] rev [NUM_BASES];
    logic [COUNT_WIDTH-1:0] unmeth;
    logic [NUM_W-1:0]       rem_sub;
    logic                   take_bit;
    logic                   out_free, load_en, calc_en, div_en, emit_en, div_last;

    always_comb
    begin
        for (int i = 0; i < NUM_BASES; i++)
        begin
            win[i] = snap_reg[SNAP_WIN_LSB + 3 * i +: 3];
            fwd[i] = snap_reg[SNAP_CNT_LSB + COUNT_WIDTH * i +: COUNT_WIDTH];
            rev[i] = snap_reg[SNAP_CNT_LSB + COUNT_WIDTH * (NUM_BASES + i) +: COUNT_WIDTH];
        end
    end

    assign out_free = !valid_reg || pop;
    assign div_last = (step_reg == STEP_W'(LEVEL_W - 1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!snap_empty) state_next = ST_CALC;
            ST_CALC: state_next = ST_DIV;
            ST_DIV:  if (div_last) state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_en = 1'b0;
        calc_en = 1'b0;
        div_en  = 1'b0;
        emit_en = 1'b0;
        case (state_reg)
            ST_IDLE: load_en = !snap_empty;
            ST_CALC: calc_en = 1'b1;
            ST_DIV:  div_en = 1'b1;
            ST_EMIT: emit_en = out_free;
            default: ;
        endcase
    end

    assign snap_pop = load_en;

    // context and counts for the site
    always_comb
    begin
        ctx_next  = CTX_NONE;
        sub_next  = SUB_ABSENT;
        meth_next = '0;
        unmeth    = '0;
        if (snap_reg[SNAP_FLAG_BIT])
        begin
            if (win[2] == BASE_C)
            begin
                sub_next = win[3];
                if (win[3] == BASE_G)
                    ctx_next = CTX_CG;
                else if (win[3] != BASE_N)
                    ctx_next = (win[4] == BASE_G) ? CTX_CHG :
                               ((win[4] != BASE_N) ? CTX_CHH : CTX_NONE);
            end
            else if (win[2] == BASE_G)
            begin
                sub_next = complement_base(win[1]);
                if (win[1] == BASE_C)
                    ctx_next = CTX_CG;
                else if (win[1] != BASE_N)
                    ctx_next = (win[0] == BASE_C) ? CTX_CHG :
                               ((win[0] != BASE_N) ? CTX_CHH : CTX_NONE);
            end
        end
        if (win[2] == BASE_C)
        begin
            meth_next = fwd[BASE_C];
            unmeth    = fwd[BASE_T];
        end
        else if (win[2] == BASE_G)
        begin
            meth_next = rev[BASE_G];
            unmeth    = rev[BASE_A];
        end
        total_next = TOT_W'(meth_next) + TOT_W'(unmeth);
    end

    // restoring divide step, quotient below 128
    assign take_bit = (rem_reg >= dsh_reg);
    assign rem_sub  = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_en)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
            if (calc_en)
                step_reg <= '0;
            else if (div_en)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            snap_reg <= snap;
        if (calc_en)
        begin
            ctx_reg   <= ctx_next;
            sub_reg   <= sub_next;
            meth_reg  <= meth_next;
            total_reg <= total_next;
            rem_reg   <= NUM_W'(meth_next) * NUM_W'(LEVEL_SCALE) + NUM_W'(total_next);
            dsh_reg   <= NUM_W'(total_next) << LEVEL_W;
            quo_reg   <= '0;
        end
        if (div_en)
        begin
            if (take_bit)
                rem_reg <= rem_sub;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[LEVEL_W-2:0], take_bit};
        end
        if (emit_en)
            result_reg <= result_next;
    end

    // result word with saturated counts
    always_comb
    begin
        logic [SAT_W-1:0] ext;
        result_next = '0;
        result_next.position_one_based = {1'b0, snap_reg[SNAP_POS_LSB +: 32]} + 33'd1;
        result_next.ref_base      = win[2];
        result_next.context_class = ctx_reg;
        result_next.sub_second    = sub_reg;
        for (int i = 0; i < NUM_BASES; i++)
        begin
            ext = SAT_W'(fwd[i]);
            result_next.forward_counts[OUT_COUNT_W * i +: OUT_COUNT_W] =
                (ext > SAT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_W'(OUT_COUNT_MAX) : ext[OUT_COUNT_W-1:0];
            ext = SAT_W'(rev[i]);
            result_next.reverse_counts[OUT_COUNT_W * i +: OUT_COUNT_W] =
                (ext > SAT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_W'(OUT_COUNT_MAX) : ext[OUT_COUNT_W-1:0];
        end
        ext = SAT_W'(meth_reg);
        result_next.meth_count =
            (ext > SAT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_W'(OUT_COUNT_MAX) : ext[OUT_COUNT_W-1:0];
        ext = SAT_W'(total_reg);
        result_next.total_count =
            (ext > SAT_W'(OUT_TOTAL_MAX)) ? OUT_TOTAL_W'(OUT_TOTAL_MAX) : ext[OUT_TOTAL_W-1:0];
        result_next.level_valid = (total_reg != '0);
        result_next.level_hundredths = (total_reg != '0) ? quo_reg : '0;
    end

    assign result = result_reg;
    assign empty  = !valid_reg;

endmodule

// ----- sv/methylation_pileup_caller.sv -----
// a column is queued with its last word; the back end then loads, calls, divides and emits it
// throughput: one word per cycle on the input while the queue has room; the back end ends one
//   column, through the 7-step restoring divider for the level in hundredths, before the next
// reset: rst_n asynchronous, active low; tallies zero, window bases other, queues empty
module methylation_pileup_caller #(
    parameter int COUNT_WIDTH = mpc_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = mpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mpc_pkg::mpc_in_t  item,
    output logic              empty,
    input  logic              pop,
    output mpc_pkg::mpc_out_t result
);
    import mpc_pkg::*;

    // one column snapshot: position, window, bounds flag, both strands' tallies
    localparam int SNAP_W = SNAP_CNT_LSB + 2 * NUM_BASES * COUNT_WIDTH;

    logic              take;
    logic              snap_push, snap_pop, snap_empty;
    logic [SNAP_W-1:0] snap_in, snap_out;

    // a word is taken whenever the column queue has room
    assign take = push && !full;

    // front: keeps the window and tallies, one word per cycle while the queue has room
    mpc_front #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .SNAP_W(SNAP_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .item(item),
        .snap_push(snap_push),
        .snap(snap_in)
    );

    // short queue of finished columns between front and back
    mpc_fifo #(
        .WIDTH(SNAP_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(snap_push),
        .wdata(snap_in),
        .full(full),
        .pop(snap_pop),
        .rdata(snap_out),
        .empty(snap_empty)
    );

    // back: context call, counts, level division, result register
    mpc_back #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .SNAP_W(SNAP_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .snap(snap_out),
        .snap_empty(snap_empty),
        .snap_pop(snap_pop),
        .result(result),
        .empty(empty),
        .pop(pop)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import mpc_pkg::*;

    // run limits and stimulus sizes
    localparam int LIMIT_CYCLES = 1000000;
    localparam int TALLY_MAX = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int RANDOM_WORDS_A = 800;
    localparam int RANDOM_WORDS_B = 800;
    localparam int DEEP_ROUNDS = 50;
    // last words go out with both sides streaming
    localparam int QUIET_TAIL = 200;
    // receiver blackout long enough to back the block up into full
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AFTER_WORDS = 300;
    // trailing cycles after the last column
    localparam int DRAIN_CYCLES = 40;

    // one pending input word, optionally held back until all columns are out
    typedef struct {
        mpc_in_t word;
        bit      drain_first;
    } queued_word_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     push;
    logic     full;
    mpc_in_t  item;
    logic     empty;
    logic     pop;
    mpc_out_t result;

    // stimulus and expected column calls
    queued_word_t word_queue[$];
    mpc_out_t     expected_calls[$];

    // predictor copy of the pileup state
    int         fwd_tally[NUM_BASES];
    int         rev_tally[NUM_BASES];
    logic [2:0] win_base[5];
    logic       win_flag;
    logic [31:0] held_pos;

    int  errors = 0;
    int  cycle_count = 0;
    int  words_taken = 0;
    bit  word_taken = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    methylation_pileup_caller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor: consumes one accepted word, returns 1 with the column
    // call when the word closes a column
    // ---------------------------------------------------------------
    function automatic logic [OUT_COUNT_W-1:0] clip_count(input int v);
        return OUT_COUNT_W'((v > OUT_COUNT_MAX) ? OUT_COUNT_MAX : v);
    endfunction

    function automatic bit call_column(input mpc_in_t w, output mpc_out_t r);
        logic [2:0] raw[5];
        logic [2:0] centre;
        logic [2:0] near;
        logic [2:0] far;
        logic [2:0] rb;
        int meth;
        int total;
        r = '0;
        if (w.kind == KIND_HEADER)
        begin
            // header loads the window, out of range codes fold to other
            raw[0] = w.ref_minus2;
            raw[1] = w.ref_minus1;
            raw[2] = w.ref_center;
            raw[3] = w.ref_plus1;
            raw[4] = w.ref_plus2;
            for (int i = 0; i < 5; i++)
                win_base[i] = (raw[i] > BASE_N) ? BASE_N : raw[i];
            win_flag = w.window_in_bounds;
            held_pos = w.column_position;
            for (int i = 0; i < NUM_BASES; i++)
            begin
                fwd_tally[i] = 0;
                rev_tally[i] = 0;
            end
        end
        else if (!w.is_indel)
        begin
            // one-hot nucleotide, anything else counts as other
            case (w.read_base)
                READ_A:  rb = BASE_A;
                READ_C:  rb = BASE_C;
                READ_G:  rb = BASE_G;
                READ_T:  rb = BASE_T;
                default: rb = BASE_N;
            endcase
            if (w.reverse_strand)
            begin
                if (rev_tally[rb] < TALLY_MAX)
                    rev_tally[rb]++;
            end
            else if (fwd_tally[rb] < TALLY_MAX)
                fwd_tally[rb]++;
        end

        if (!w.last_in_column)
            return 1'b0;

        centre = win_base[2];
        r.context_class = CTX_NONE;
        r.sub_second = SUB_ABSENT;
        meth = 0;
        total = 0;
        if (centre == BASE_C)
        begin
            // c site: forward c methylated, forward t converted
            near = win_base[3];
            far = win_base[4];
            meth = fwd_tally[BASE_C];
            total = meth + fwd_tally[BASE_T];
            if (win_flag)
            begin
                r.sub_second = near;
                if (near == BASE_G)
                    r.context_class = CTX_CG;
                else if (near != BASE_N)
                    r.context_class = (far == BASE_G) ? CTX_CHG :
                                      (far != BASE_N) ? CTX_CHH : CTX_NONE;
            end
        end
        else if (centre == BASE_G)
        begin
            // g site: mirror on the reverse strand, context read leftward
            near = win_base[1];
            far = win_base[0];
            meth = rev_tally[BASE_G];
            total = meth + rev_tally[BASE_A];
            if (win_flag)
            begin
                case (near)
                    BASE_A:  r.sub_second = BASE_T;
                    BASE_T:  r.sub_second = BASE_A;
                    BASE_C:  r.sub_second = BASE_G;
                    BASE_G:  r.sub_second = BASE_C;
                    default: r.sub_second = BASE_N;
                endcase
                if (near == BASE_C)
                    r.context_class = CTX_CG;
                else if (near != BASE_N)
                    r.context_class = (far == BASE_C) ? CTX_CHG :
                                      (far != BASE_N) ? CTX_CHH : CTX_NONE;
            end
        end

        r.position_one_based = {1'b0, held_pos} + 33'd1;
        r.ref_base = centre;
        for (int i = 0; i < NUM_BASES; i++)
        begin
            r.forward_counts[OUT_COUNT_W*i +: OUT_COUNT_W] = clip_count(fwd_tally[i]);
            r.reverse_counts[OUT_COUNT_W*i +: OUT_COUNT_W] = clip_count(rev_tally[i]);
        end
        r.meth_count = clip_count(meth);
        r.total_count = OUT_TOTAL_W'((total > OUT_TOTAL_MAX) ? OUT_TOTAL_MAX : total);
        // level in hundredths, round half up, undefined on zero coverage
        if (total != 0)
        begin
            r.level_hundredths = LEVEL_W'((LEVEL_SCALE * meth + total) / (2 * total));
            r.level_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // field by field comparison of one column call
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void compare_call(input mpc_out_t want, input mpc_out_t got);
        check_field("position_one_based", 64'(want.position_one_based),
                    64'(got.position_one_based));
        check_field("ref_base", 64'(want.ref_base), 64'(got.ref_base));
        check_field("context_class", 64'(want.context_class), 64'(got.context_class));
        check_field("sub_second", 64'(want.sub_second), 64'(got.sub_second));
        check_field("forward_counts", 64'(want.forward_counts), 64'(got.forward_counts));
        check_field("reverse_counts", 64'(want.reverse_counts), 64'(got.reverse_counts));
        check_field("meth_count", 64'(want.meth_count), 64'(got.meth_count));
        check_field("total_count", 64'(want.total_count), 64'(got.total_count));
        check_field("level_hundredths", 64'(want.level_hundredths),
                    64'(got.level_hundredths));
        check_field("level_valid", 64'(want.level_valid), 64'(got.level_valid));
    endfunction

    // ---------------------------------------------------------------
    // word builders, fields the block ignores carry random noise
    // ---------------------------------------------------------------
    function automatic mpc_in_t noise_word();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[$bits(mpc_in_t)-1:0];
    endfunction

    function automatic mpc_in_t header_word(input logic [2:0] m2, input logic [2:0] m1,
                                            input logic [2:0] c, input logic [2:0] p1,
                                            input logic [2:0] p2, input logic inb,
                                            input logic [31:0] pos, input logic last);
        mpc_in_t w;
        w = noise_word();
        w.kind = KIND_HEADER;
        w.ref_minus2 = m2;
        w.ref_minus1 = m1;
        w.ref_center = c;
        w.ref_plus1 = p1;
        w.ref_plus2 = p2;
        w.window_in_bounds = inb;
        w.column_position = pos;
        w.last_in_column = last;
        return w;
    endfunction

    function automatic mpc_in_t read_word(input logic [3:0] code, input logic rev,
                                          input logic indel, input logic last);
        mpc_in_t w;
        w = noise_word();
        w.kind = KIND_READ;
        w.read_base = code;
        w.reverse_strand = rev;
        w.is_indel = indel;
        w.last_in_column = last;
        return w;
    endfunction

    task automatic add_word(input mpc_in_t w, input bit drain);
        word_queue.push_back('{w, drain});
    endtask

    // flanking base, mostly real nucleotides, sometimes other or out of range
    function automatic logic [2:0] pick_flank();
        if ($urandom_range(0, 7) == 0)
            return 3'($urandom_range(4, 7));
        return 3'($urandom_range(0, 3));
    endfunction

    // well formed columns with random content, plus headers that close at
    // once and stray reads with no header in front
    task automatic add_random_columns(input int target, input bit drain_at_start);
        int added;
        int shape;
        int n;
        int pick;
        bit drain;
        logic [2:0] centre;
        logic [3:0] code;
        added = 0;
        drain = drain_at_start;
        while (added < target)
        begin
            shape = $urandom_range(0, 19);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
            if (shape == 0)
                n = 0;
            if (shape != 1)
            begin
                pick = $urandom_range(0, 9);
                centre = (pick < 4) ? BASE_C : (pick < 8) ? BASE_G : 3'($urandom_range(0, 7));
                add_word(header_word(pick_flank(), pick_flank(), centre, pick_flank(),
                                     pick_flank(), $urandom_range(0, 9) != 0, $urandom,
                                     n == 0), drain);
                drain = 1'b0;
                added++;
            end
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 5) == 0)
                    code = 4'($urandom_range(0, 15));
                else
                    case ($urandom_range(0, 3))
                        0:       code = READ_A;
                        1:       code = READ_C;
                        2:       code = READ_G;
                        default: code = READ_T;
                    endcase
                add_word(read_word(code, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                                   j == n - 1), drain);
                drain = 1'b0;
                added++;
            end
        end
    endtask

    // both sides may idle only outside the calm windows and the tail
    function automatic bit idle_allowed();
        return word_queue.size() >= QUIET_TAIL && (cycle_count / 300) % 3 != 0;
    endfunction

    // ---------------------------------------------------------------
    // input side: capture accepted words and run the predictor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch_input
        mpc_out_t call;
        if (rst_n && push && !full)
        begin
            if (call_column(item, call))
                expected_calls.push_back(call);
            words_taken++;
            word_taken = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result side: every popped word is checked against the oldest call
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch_output
        mpc_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_calls.size() == 0)
            begin
                $error("column result with none expected, position %0d",
                       result.position_one_based);
                errors++;
            end
            else
            begin
                want = expected_calls.pop_front();
                compare_call(want, result);
            end
        end
    end

    // ---------------------------------------------------------------
    // driver: holds a word until taken, random idle bursts, and waits at
    // marked words until every outstanding column has come back
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_input
        bit offer;
        offer = 1'b0;
        if (rst_n && !(push && !word_taken))
        begin
            word_taken = 1'b0;
            if (send_gap != 0)
                send_gap--;
            else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain_first && expected_calls.size() != 0))
            begin
                if (idle_allowed() && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(0, 15);
                else
                begin
                    offer = 1'b1;
                    item <= word_queue[0].word;
                    void'(word_queue.pop_front());
                end
            end
            push <= offer;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall bursts plus one long blackout so the block
    // fills and pushes back on the input
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_output
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!long_hold_done && words_taken >= HOLD_AFTER_WORDS)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                pop <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 15);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[methylation_pileup_caller] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        // predictor reset state
        for (int i = 0; i < NUM_BASES; i++)
        begin
            fwd_tally[i] = 0;
            rev_tally[i] = 0;
        end
        for (int i = 0; i < 5; i++)
            win_base[i] = BASE_N;
        win_flag = 1'b0;
        held_pos = '0;

        // cg site, every nucleotide on both strands, unassigned codes, indel
        add_word(header_word(BASE_A, BASE_T, BASE_C, BASE_G, BASE_A, 1'b1, 32'd0, 1'b0), 1'b0);
        add_word(read_word(READ_A, 1'b0, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_C, 1'b0, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_G, 1'b0, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_T, 1'b0, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_A, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_C, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_G, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_T, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(4'h0, 1'b0, 1'b0, 1'b0), 1'b0);
        add_word(read_word(4'hF, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_C, 1'b0, 1'b1, 1'b0), 1'b0);
        add_word(read_word(READ_C, 1'b0, 1'b0, 1'b1), 1'b0);
        // header that closes its own column, chg, top position, codes above other
        add_word(header_word(3'd5, 3'd6, BASE_C, BASE_T, BASE_G, 1'b1, 32'hFFFF_FFFF, 1'b1),
                 1'b0);
        // g site chg, then a stray read that keeps counting into it
        add_word(header_word(BASE_C, BASE_A, BASE_G, BASE_T, BASE_C, 1'b1, $urandom, 1'b0),
                 1'b0);
        add_word(read_word(READ_G, 1'b1, 1'b0, 1'b0), 1'b0);
        add_word(read_word(READ_A, 1'b1, 1'b0, 1'b1), 1'b0);
        add_word(read_word(READ_G, 1'b1, 1'b0, 1'b1), 1'b0);
        // centre neither c nor g
        add_word(header_word(BASE_G, BASE_C, BASE_T, BASE_C, BASE_G, 1'b1, $urandom, 1'b0),
                 1'b0);
        add_word(read_word(READ_C, 1'b0, 1'b0, 1'b1), 1'b0);
        // window out of bounds, counts still taken
        add_word(header_word(BASE_T, BASE_T, BASE_C, BASE_G, BASE_G, 1'b0, $urandom, 1'b0),
                 1'b0);
        add_word(read_word(READ_T, 1'b0, 1'b0, 1'b1), 1'b0);
        // g site chh, g site with other at -1, c site with other at +2
        add_word(header_word(BASE_T, BASE_G, BASE_G, BASE_A, BASE_A, 1'b1, $urandom, 1'b1),
                 1'b0);
        add_word(header_word(3'd7, 3'd7, BASE_G, BASE_A, BASE_A, 1'b1, $urandom, 1'b1), 1'b0);
        add_word(header_word(BASE_A, BASE_A, BASE_C, BASE_A, BASE_N, 1'b1, $urandom, 1'b1),
                 1'b0);

        // random columns, sender first waits for the directed columns
        add_random_columns(RANDOM_WORDS_A, 1'b1);

        // deep column: fwd c, t; rev g, a; one word per cycle unless stalled
        add_word(header_word(BASE_A, BASE_C, BASE_C, BASE_G, BASE_T, 1'b1, $urandom, 1'b0),
                 1'b1);
        for (int r = 0; r < DEEP_ROUNDS; r++)
        begin
            add_word(read_word(READ_C, 1'b0, 1'b0, 1'b0), 1'b0);
            add_word(read_word(READ_T, 1'b0, 1'b0, 1'b0), 1'b0);
            add_word(read_word(READ_G, 1'b1, 1'b0, 1'b0), 1'b0);
            add_word(read_word(READ_A, 1'b1, 1'b0, r == DEEP_ROUNDS - 1), 1'b0);
        end

        add_random_columns(RANDOM_WORDS_B, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all words in, all columns back, then a quiet stretch
        while (word_queue.size() != 0 || push)
            @(posedge clk);
        while (expected_calls.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[methylation_pileup_caller] OK");
        else
            $display("[methylation_pileup_caller] ERROR");
        $finish;
    end

endmodule
